/* design/mas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int DUTY_W     = 16;
   localparam int STEP_W     = 8;
   localparam int HOLD_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int WINDOW_DEF = 15;
   localparam int FULL_SCALE = 4095;

   // level * |span| stays below 2^28; floor(2^28 / 4095) leaves the quotient
   // at most one short, fixed by a single compare
   localparam int MAP_PROD_W  = SAMPLE_W + DUTY_W;
   localparam int MAP_RECIP_W = 17;
   localparam int MAP_REC_W   = MAP_PROD_W + MAP_RECIP_W;
   localparam logic [MAP_RECIP_W-1:0] MAP_RECIP =
      MAP_RECIP_W'((2 ** MAP_PROD_W) / FULL_SCALE);
   localparam logic [MAP_PROD_W-1:0] MAP_DIVISOR = MAP_PROD_W'(FULL_SCALE);

   // (d * 27) / 10 == (d * 27 * 52429) >> 19, exact for d below 256
   localparam int HOLD_MUL_W = 21;
   localparam int HOLD_SH    = 19;
   localparam logic [HOLD_MUL_W-1:0] HOLD_MUL = HOLD_MUL_W'(27 * 52429);

   localparam logic [DUTY_W-1:0] DUTY_ZERO_RST  = DUTY_W'(3800);
   localparam logic [DUTY_W-1:0] DUTY_FULL_RST  = DUTY_W'(1835);
   localparam logic [STEP_W-1:0] STEP_RST       = STEP_W'(8);
   localparam logic [HOLD_W-1:0] HOLD_LIM_RST   = HOLD_W'(15);
   localparam logic [DUTY_W-1:0] DUTY_MAX       = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DUTY_ZERO = 2'd0,
      CSR_DUTY_FULL = 2'd1,
      CSR_STEP      = 2'd2,
      CSR_HOLD_LIM  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic mul_en;
      logic recip_en;
      logic out_en;
   } map_ctl_type;

endpackage

`default_nettype wire

/* design/mas_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module mas_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          shift_en,
   input  wire logic [mas_pkg::SAMPLE_W-1:0]  tap_in,
   output logic      [mas_pkg::SAMPLE_W-1:0]  tap_out
);
   import mas_pkg::*;

   logic [SAMPLE_W-1:0] tap_ff;
   logic [SAMPLE_W-1:0] tap_in_w;

   assign tap_in_w = shift_en ? tap_in : tap_ff;
   assign tap_out  = tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in_w;
      end
   end

endmodule

`default_nettype wire

/* design/mas_map.sv */
`timescale 1ns / 1ps
`default_nettype none

// duty = lo + level * (hi - lo) / 4095, truncated toward zero, over three stages
module mas_map (
   input  wire logic                         clock,
   input  wire mas_pkg::map_ctl_type         ctl,
   input  wire logic [mas_pkg::SAMPLE_W-1:0] level,
   input  wire logic [mas_pkg::DUTY_W-1:0]   duty_lo,
   input  wire logic [mas_pkg::DUTY_W-1:0]   span_mag,
   input  wire logic                         span_neg,
   output logic      [mas_pkg::DUTY_W-1:0]   duty
);
   import mas_pkg::*;

   logic [MAP_PROD_W-1:0] prod_ff;
   logic [MAP_PROD_W-1:0] x_ff;
   logic [MAP_REC_W-1:0]  rec_ff;
   logic [DUTY_W-1:0]     duty_ff;

   logic [DUTY_W-1:0]     q0;
   logic [MAP_PROD_W-1:0] rem;
   logic [DUTY_W-1:0]     quot;
   logic [DUTY_W:0]       duty_in;

   always_comb begin
      // reciprocal is scaled by 2^28, so the quotient starts at bit 28
      q0   = rec_ff[MAP_PROD_W +: DUTY_W];
      rem  = x_ff - MAP_PROD_W'(q0 * MAP_DIVISOR);
      quot = q0 + DUTY_W'(rem >= MAP_DIVISOR);
      // result lies between lo and hi, so 16 bits hold it
      if (span_neg) begin
         duty_in = {1'b0, duty_lo} - {1'b0, quot};
      end else begin
         duty_in = {1'b0, duty_lo} + {1'b0, quot};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= MAP_PROD_W'(level * span_mag);
      end
      if (ctl.recip_en) begin
         rec_ff <= MAP_REC_W'(prod_ff * MAP_RECIP);
         x_ff   <= prod_ff;
      end
      if (ctl.out_en) begin
         duty_ff <= duty_in[DUTY_W-1:0];
      end
   end

   assign duty = duty_ff;

endmodule

`default_nettype wire

/* design/moving_average_servo_slew_limiter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    req_sample
// rsp_      out        rsp_valid/stall    pwm_duty, hold_ms, step_limited, filtered_level
// csr_      in         csr_valid/ready    csr_index, csr_data
//
// One request per cycle while rsp_stall does not hold back a full pipeline.
// The rate is set by the running-sum update, one add and subtract per cycle.
// Every stage holds its own valid bit: bubbles close up, so requests are taken
// while a result waits on rsp_stall until all seven stages are full.
// Reset clears the sample cells, running sum and previous level at once.
module moving_average_servo_slew_limiter #(
   parameter int WINDOW = mas_pkg::WINDOW_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [mas_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [mas_pkg::DUTY_W-1:0]      rsp_pwm_duty,
   output logic      [mas_pkg::HOLD_W-1:0]      rsp_hold_ms,
   output logic                                 rsp_step_limited,
   output logic      [mas_pkg::SAMPLE_W-1:0]    rsp_filtered_level,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mas_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mas_pkg::*;

   localparam int NSTAGE = 7;
   localparam int SUM_W  = $clog2(WINDOW * FULL_SCALE + 1);
   localparam logic [SUM_W-1:0]   WINDOW_C = SUM_W'(WINDOW);
   localparam logic [SUM_W-1:0]   DIV_M    = SUM_W'((2 ** SUM_W) / WINDOW);
   localparam logic [HOLD_W-1:0]  HOLD_UNLIM_MAX = HOLD_W'((255 * 27) / 10);

   // configuration
   logic [DUTY_W-1:0] duty_zero_ff;
   logic [DUTY_W-1:0] duty_full_ff;
   logic [STEP_W-1:0] step_ff;
   logic [HOLD_W-1:0] hold_lim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_zero_ff <= DUTY_ZERO_RST;
         duty_full_ff <= DUTY_FULL_RST;
         step_ff      <= STEP_RST;
         hold_lim_ff  <= HOLD_LIM_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DUTY_ZERO: duty_zero_ff <= csr_data;
            CSR_DUTY_FULL: duty_full_ff <= csr_data;
            CSR_STEP:      step_ff      <= csr_data[STEP_W-1:0];
            CSR_HOLD_LIM:  hold_lim_ff  <= csr_data[HOLD_W-1:0];
         endcase
      end
   end

   // stage flow control
   logic [NSTAGE:1] v_ff;
   logic [NSTAGE:1] v_in;
   logic [NSTAGE:1] free;
   logic [NSTAGE:1] go;

   always_comb begin
      free[NSTAGE] = !v_ff[NSTAGE] || !rsp_stall;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         free[k] = !v_ff[k] || free[k+1];
      end
      go[1]   = req_valid && free[1];
      v_in[1] = free[1] ? req_valid : v_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         go[k]   = v_ff[k-1] && free[k];
         v_in[k] = free[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !free[1];

   // window: a row of cells shifting one place per request
   logic [SAMPLE_W-1:0] tap [WINDOW];

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            mas_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (go[1]),
               .tap_in   (req_sample),
               .tap_out  (tap[gi])
            );
         end else begin : g_body
            mas_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (go[1]),
               .tap_in   (tap[gi-1]),
               .tap_out  (tap[gi])
            );
         end
      end
   endgenerate

   // stage 1: running sum
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   assign sum_in = go[1] ? (sum_ff - SUM_W'(tap[WINDOW-1]) + SUM_W'(req_sample)) : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // stage 2: sum times reciprocal of the window size
   logic [2*SUM_W-1:0] dprod2_ff;
   logic [SUM_W-1:0]   sum2_ff;

   always_ff @(posedge clock) begin
      if (go[2]) begin
         dprod2_ff <= (2*SUM_W)'(sum_ff * DIV_M);
         sum2_ff   <= sum_ff;
      end
   end

   // stage 3: quotient correction, previous level pairing
   logic [SUM_W-1:0]    q0_full;
   logic [SAMPLE_W-1:0] q0;
   logic [SUM_W-1:0]    drem;
   logic [SAMPLE_W-1:0] level_c;
   logic [SAMPLE_W-1:0] lvl3_ff;
   logic [SAMPLE_W-1:0] prv3_ff;
   logic [SAMPLE_W-1:0] last_ff;

   always_comb begin
      q0_full = dprod2_ff[2*SUM_W-1 -: SUM_W];
      q0      = q0_full[SAMPLE_W-1:0];
      drem    = sum2_ff - SUM_W'(q0 * WINDOW_C);
      level_c = q0 + SAMPLE_W'(drem >= WINDOW_C);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (go[3]) begin
         last_ff <= level_c;
      end
   end

   always_ff @(posedge clock) begin
      if (go[3]) begin
         lvl3_ff <= level_c;
         prv3_ff <= last_ff;
      end
   end

   // stages 4 to 6: two mapping lanes
   logic              span_neg;
   logic [DUTY_W-1:0] span_mag;
   map_ctl_type       map_ctl;
   logic [DUTY_W-1:0] cur6;
   logic [DUTY_W-1:0] pre6;

   assign span_neg = duty_full_ff < duty_zero_ff;
   assign span_mag = span_neg ? (duty_zero_ff - duty_full_ff) : (duty_full_ff - duty_zero_ff);

   always_comb begin
      map_ctl.mul_en   = go[4];
      map_ctl.recip_en = go[5];
      map_ctl.out_en   = go[6];
   end

   mas_map u_map_cur (
      .clock    (clock),
      .ctl      (map_ctl),
      .level    (lvl3_ff),
      .duty_lo  (duty_zero_ff),
      .span_mag (span_mag),
      .span_neg (span_neg),
      .duty     (cur6)
   );

   mas_map u_map_pre (
      .clock    (clock),
      .ctl      (map_ctl),
      .level    (prv3_ff),
      .duty_lo  (duty_zero_ff),
      .span_mag (span_mag),
      .span_neg (span_neg),
      .duty     (pre6)
   );

   logic [SAMPLE_W-1:0] lvl4_ff;
   logic [SAMPLE_W-1:0] lvl5_ff;
   logic [SAMPLE_W-1:0] lvl6_ff;

   always_ff @(posedge clock) begin
      if (go[4]) begin
         lvl4_ff <= lvl3_ff;
      end
      if (go[5]) begin
         lvl5_ff <= lvl4_ff;
      end
      if (go[6]) begin
         lvl6_ff <= lvl5_ff;
      end
   end

   // stage 7: slew limit and output register
   logic signed [DUTY_W:0]        diff;
   logic [DUTY_W-1:0]             dmag;
   logic [HOLD_W+HOLD_SH-1:0]     hprod;
   logic [DUTY_W:0]               up_sum;
   logic signed [DUTY_W+1:0]      dn_sum;
   logic [DUTY_W-1:0]             duty_in;
   logic [HOLD_W-1:0]             hold_in;
   logic                          lim_in;

   logic [DUTY_W-1:0]   duty_ff;
   logic [HOLD_W-1:0]   hold_ff;
   logic                lim_ff;
   logic [SAMPLE_W-1:0] level_ff;

   always_comb begin
      diff   = $signed({1'b0, cur6}) - $signed({1'b0, pre6});
      dmag   = diff[DUTY_W] ? DUTY_W'(-diff) : diff[DUTY_W-1:0];
      // only used when dmag < step, so its low byte is the whole value
      hprod  = (HOLD_W+HOLD_SH)'(dmag[STEP_W-1:0] * HOLD_MUL);
      up_sum = {1'b0, pre6} + (DUTY_W+1)'(step_ff);
      dn_sum = $signed({2'b00, pre6}) - $signed((DUTY_W+2)'(step_ff));
      if (dmag < DUTY_W'(step_ff)) begin
         duty_in = cur6;
         hold_in = hprod[HOLD_W+HOLD_SH-1 -: HOLD_W];
         lim_in  = 1'b0;
      end else begin
         if (diff > 0) begin
            duty_in = up_sum[DUTY_W] ? DUTY_MAX : up_sum[DUTY_W-1:0];
         end else begin
            duty_in = dn_sum[DUTY_W+1] ? '0 : dn_sum[DUTY_W-1:0];
         end
         hold_in = hold_lim_ff;
         lim_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (go[7]) begin
         duty_ff  <= duty_in;
         hold_ff  <= hold_in;
         lim_ff   <= lim_in;
         level_ff <= lvl6_ff;
      end
   end

   assign rsp_valid          = v_ff[NSTAGE];
   assign rsp_pwm_duty       = duty_ff;
   assign rsp_hold_ms        = hold_ff;
   assign rsp_step_limited   = lim_ff;
   assign rsp_filtered_level = level_ff;

`ifndef SYNTH
   a_unlim_hold_small: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_step_limited |-> rsp_hold_ms <= HOLD_UNLIM_MAX)
      else $error("unlimited hold time out of range");

   a_empty_head_ready: assert property (@(posedge clock) disable iff (reset)
      !v_ff[1] |-> !req_stall)
      else $error("request stalled with empty first stage");

   a_take_fills_head: assert property (@(posedge clock) disable iff (reset)
      go[1] |=> v_ff[1])
      else $error("taken request lost at first stage");

   a_prev_level_tracks: assert property (@(posedge clock) disable iff (reset)
      go[3] |=> last_ff == lvl3_ff)
      else $error("previous level not updated with current level");

   a_level_bounded: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] |-> sum_ff <= SUM_W'(WINDOW * FULL_SCALE))
      else $error("running sum exceeds window full scale");
`endif

endmodule

`default_nettype wire

/* bench/mas_servo_checker.sv */
`timescale 1ns / 1ps

module mas_servo_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic [mas_pkg::SAMPLE_W-1:0]    req_sample,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [mas_pkg::DUTY_W-1:0]      rsp_pwm_duty,
   input  wire logic [mas_pkg::HOLD_W-1:0]      rsp_hold_ms,
   input  wire logic                            rsp_step_limited,
   input  wire logic [mas_pkg::SAMPLE_W-1:0]    rsp_filtered_level,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [mas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mas_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                   fail_count,
   output int                                   pending
);
   import mas_pkg::*;

   localparam int     HOLD_NUM = 27;
   localparam int     HOLD_DEN = 10;
   localparam longint HOLD_CAP = 1023;
   localparam longint DUTY_TOP = 65535;

   typedef struct packed {
      logic [DUTY_W-1:0]   duty;
      logic [HOLD_W-1:0]   hold;
      logic                limited;
      logic [SAMPLE_W-1:0] level;
   } servo_cmd_type;

   logic [SAMPLE_W-1:0] ring_cells [WINDOW_DEF];
   int unsigned         ring_pos;
   logic [15:0]         ring_sum;
   logic [SAMPLE_W-1:0] last_level;

   logic [DUTY_W-1:0]   cfg_zero;
   logic [DUTY_W-1:0]   cfg_full;
   logic [STEP_W-1:0]   cfg_step;
   logic [HOLD_W-1:0]   cfg_hold;

   servo_cmd_type       servo_cmd_q [$];
   int                  errs = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // linear map onto the duty range, division truncates toward zero
   function automatic longint map_to_duty(input logic [SAMPLE_W-1:0] lvl);
      longint lo;
      longint hi;
      longint x;
      lo = cfg_zero;
      hi = cfg_full;
      x  = lvl;
      return lo + (x * (hi - lo)) / FULL_SCALE;
   endfunction

   function automatic servo_cmd_type predict_servo_cmd(input logic [SAMPLE_W-1:0] s);
      servo_cmd_type       r;
      logic [SAMPLE_W-1:0] lvl;
      longint              cur;
      longint              prev;
      longint              diff;
      longint              mag;
      longint              duty;
      longint              hold;
      longint              stepv;
      ring_sum = ring_sum - ring_cells[ring_pos] + s;
      ring_cells[ring_pos] = s;
      ring_pos = (ring_pos == WINDOW_DEF - 1) ? 0 : ring_pos + 1;
      lvl   = SAMPLE_W'(ring_sum / WINDOW_DEF);
      cur   = map_to_duty(lvl);
      prev  = map_to_duty(last_level);
      diff  = cur - prev;
      mag   = (diff < 0) ? -diff : diff;
      stepv = cfg_step;
      if (mag < stepv) begin
         duty = cur;
         hold = (mag * HOLD_NUM) / HOLD_DEN;
         if (hold > HOLD_CAP) hold = HOLD_CAP;
         r.limited = 1'b0;
      end else begin
         // an equal pair moves down by the step (zero step keeps it)
         duty = (diff > 0) ? prev + stepv : prev - stepv;
         hold = cfg_hold;
         r.limited = 1'b1;
      end
      if (duty < 0) duty = 0;
      if (duty > DUTY_TOP) duty = DUTY_TOP;
      last_level = lvl;
      r.duty  = DUTY_W'(duty);
      r.hold  = HOLD_W'(hold);
      r.level = lvl;
      return r;
   endfunction

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errs++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      servo_cmd_type exp_cmd;
      if (reset) begin
         foreach (ring_cells[i]) ring_cells[i] = '0;
         ring_pos   = 0;
         ring_sum   = '0;
         last_level = '0;
         cfg_zero   = DUTY_ZERO_RST;
         cfg_full   = DUTY_FULL_RST;
         cfg_step   = STEP_RST;
         cfg_hold   = HOLD_LIM_RST;
         servo_cmd_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DUTY_ZERO: cfg_zero = csr_data;
               CSR_DUTY_FULL: cfg_full = csr_data;
               CSR_STEP:      cfg_step = csr_data[STEP_W-1:0];
               CSR_HOLD_LIM:  cfg_hold = csr_data[HOLD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (servo_cmd_q.size() == 0) begin
               errs++;
               $display("%0t unexpected result: expected none actual duty %0d level %0d",
                        $time, rsp_pwm_duty, rsp_filtered_level);
            end else begin
               exp_cmd = servo_cmd_q.pop_front();
               check_field("pwm_duty", exp_cmd.duty, rsp_pwm_duty);
               check_field("hold_ms", exp_cmd.hold, rsp_hold_ms);
               check_field("step_limited", exp_cmd.limited, rsp_step_limited);
               check_field("filtered_level", exp_cmd.level, rsp_filtered_level);
            end
         end
         if (req_valid && !req_stall)
            servo_cmd_q.push_back(predict_servo_cmd(req_sample));
      end
      pending    <= servo_cmd_q.size();
      fail_count <= errs;
   end

endmodule

/* bench/tb_moving_average_servo_slew_limiter.sv */
`timescale 1ns / 1ps

module tb_moving_average_servo_slew_limiter;
   import mas_pkg::*;

   localparam int MAX_GAP      = 17;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 141;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_stall  = 1'b0;
   logic                  csr_valid  = 1'b0;
   csr_idx_type           csr_index  = CSR_DUTY_ZERO;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic [DUTY_W-1:0]     rsp_pwm_duty;
   logic [HOLD_W-1:0]     rsp_hold_ms;
   logic                  rsp_step_limited;
   logic [SAMPLE_W-1:0]   rsp_filtered_level;
   logic                  csr_ready;

   int fail_count;
   int pending;
   bit idle_on       = 1'b1;
   bit long_hold_req = 1'b0;
   int idle_cycles   = 0;
   int walk_level    = 2048;

   always #5 clock = ~clock;

   moving_average_servo_slew_limiter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pwm_duty       (rsp_pwm_duty),
      .rsp_hold_ms        (rsp_hold_ms),
      .rsp_step_limited   (rsp_step_limited),
      .rsp_filtered_level (rsp_filtered_level),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   mas_servo_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pwm_duty       (rsp_pwm_duty),
      .rsp_hold_ms        (rsp_hold_ms),
      .rsp_step_limited   (rsp_step_limited),
      .rsp_filtered_level (rsp_filtered_level),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stall before each result while idle_on, one long hold on request
   initial begin : rsp_side
      int hold_n;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            hold_n = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_n > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold_n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   // pending is a registered copy of the queue size, so look after the next edge
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic put_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // upper data bits of the narrow registers carry junk that must be dropped
   task automatic program_regs(input logic [DUTY_W-1:0] zero_duty,
                               input logic [DUTY_W-1:0] full_duty,
                               input logic [STEP_W-1:0] step,
                               input logic [HOLD_W-1:0] hold_lim);
      put_reg(CSR_DUTY_ZERO, zero_duty);
      put_reg(CSR_DUTY_FULL, full_duty);
      put_reg(CSR_STEP, {8'($urandom), step});
      put_reg(CSR_HOLD_LIM, {6'($urandom), hold_lim});
      csr_valid <= 1'b0;
   endtask

   // mix of extremes, slow drift (small steps pass unlimited) and noise
   task automatic next_sample(output logic [SAMPLE_W-1:0] s);
      int drift;
      case ($urandom_range(0, 9))
         0: s = '0;
         1: s = '1;
         2, 3, 4, 5: begin
            drift = $urandom_range(0, 40);
            walk_level = walk_level + drift - 20;
            if (walk_level < 0) walk_level = 0;
            if (walk_level > FULL_SCALE) walk_level = FULL_SCALE;
            s = SAMPLE_W'(walk_level);
         end
         default: s = SAMPLE_W'($urandom);
      endcase
   endtask

   initial begin : stimulus
      logic [SAMPLE_W-1:0] s;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first request maps from duty_at_zero, full-scale jumps clamp
      send_sample(12'd0);
      repeat (4) send_sample(12'hFFF);
      repeat (3) send_sample(12'd0);
      send_sample(12'hAAA);
      send_sample(12'h555);
      send_sample(12'd2048);
      send_sample(12'd2047);
      send_sample(12'd1);
      drain_all();

      // zero step limit: every request limited, equal pair holds the duty
      program_regs(16'h0000, 16'hFFFF, 8'd0, 10'h3FF);
      repeat (2) send_sample(12'd0);
      send_sample(12'hFFF);
      send_sample(12'd7);
      drain_all();

      program_regs(16'hFFFF, 16'h0000, 8'hFF, 10'h000);
      repeat (2) send_sample(12'hFFF);
      repeat (2) send_sample(12'd0);
      drain_all();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_regs(DUTY_ZERO_RST, DUTY_FULL_RST, STEP_RST, HOLD_LIM_RST);
            1: program_regs(16'h0000, 16'hFFFF, 8'd1, 10'h3FF);
            2: program_regs(16'hFFFF, 16'h0000, 8'hFF, 10'h000);
            3: program_regs(16'h0000, 16'h0000, 8'd0, 10'($urandom));
            4: program_regs(16'd1835, 16'd3800, 8'hFF, 10'h3FF);
            default: program_regs(16'($urandom), 16'($urandom),
                                  8'($urandom_range(1, 255)), 10'($urandom));
         endcase
         idle_on       = (p != 2) && (p != 5);
         long_hold_req = (p == 2);
         repeat (PHASE_ITEMS) begin
            next_sample(s);
            send_sample(s);
         end
         drain_all();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
design/mas_pkg.sv
design/mas_cell.sv
design/mas_map.sv
design/moving_average_servo_slew_limiter.sv
bench/mas_servo_checker.sv
bench/tb_moving_average_servo_slew_limiter.sv
